[sv/bdrs_pkg.sv]
// shared types, codes and helpers for the button debounce / repeat setpoint block
package bdrs_pkg;

   localparam int TIME_BITS = 32;

   localparam int BUTTON_WIDTH   = 3;
   localparam int DEBOUNCE_WIDTH = 8;
   localparam int REPEAT_WIDTH   = 16;
   localparam int STEP_WIDTH     = 6;
   localparam int TEMP_WIDTH     = 9;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef logic [BUTTON_WIDTH-1:0]   button_type;
   typedef logic [TIME_BITS-1:0]      time_type;
   typedef logic [TEMP_WIDTH-1:0]     temp_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam button_type KEY_NONE  = 3'd0;
   localparam button_type KEY_ENTER = 3'd1;
   localparam button_type KEY_UP    = 3'd2;
   localparam button_type KEY_DOWN  = 3'd3;
   localparam button_type KEY_MENU  = 3'd4;

   localparam csr_index_type CSR_DEBOUNCE_TICKS   = 3'd0;
   localparam csr_index_type CSR_REPEAT_TICKS     = 3'd1;
   localparam csr_index_type CSR_TEMPERATURE_STEP = 3'd2;
   localparam csr_index_type CSR_MIN_TEMPERATURE  = 3'd3;
   localparam csr_index_type CSR_MAX_TEMPERATURE  = 3'd4;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_TICKS_RESET   = 8'd20;
   localparam logic [REPEAT_WIDTH-1:0]   REPEAT_TICKS_RESET     = 16'd200;
   localparam logic [STEP_WIDTH-1:0]     TEMPERATURE_STEP_RESET = 6'd10;
   localparam temp_type                  MIN_TEMPERATURE_RESET  = 9'd150;
   localparam temp_type                  MAX_TEMPERATURE_RESET  = 9'd450;
   localparam temp_type                  SETPOINT_RESET         = 9'd300;
   localparam temp_type                  SETPOINT_MAX           = 9'd511;

   typedef struct packed {
      temp_type   setpoint_value;
      button_type debounced_button;
      logic       setpoint_changed;
   } result_type;

   // level of the named button; none and unknown codes read as released
   function automatic logic level_of(input button_type btn, input logic [3:0] levels);
      logic lvl;
      begin
         case (btn)
            KEY_ENTER: lvl = levels[0];
            KEY_UP:    lvl = levels[1];
            KEY_DOWN:  lvl = levels[2];
            KEY_MENU:  lvl = levels[3];
            default:   lvl = 1'b0;
         endcase
         return lvl;
      end
   endfunction

endpackage

[sv/button_debounce_repeat_setpoint.sv]
// top level: button debounce, auto-repeat and temperature setpoint update
// One request transfer is one 1 ms tick and yields exactly one response transfer. Each tick is
// handled combinationally: the debounce, repeat and setpoint logic sits between the state
// registers and a two-entry response buffer, so a tick can be taken on every clock while the
// response side keeps up. req_stall rises only when both buffer entries hold responses that have
// not been transferred, and falls the cycle after one is taken. Configuration writes apply from
// the next tick on; the setpoint starts at 300 after reset.
module button_debounce_repeat_setpoint
   import bdrs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_press_event,
   input  logic                       req_pressed_enter,
   input  logic                       req_pressed_up,
   input  logic                       req_pressed_down,
   input  logic                       req_pressed_menu,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [8:0]                 rsp_setpoint_value,
   output logic [2:0]                 rsp_debounced_button,
   output logic                       rsp_setpoint_changed,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // configuration
   logic [DEBOUNCE_WIDTH-1:0] debounce_ticks_ff;
   logic [REPEAT_WIDTH-1:0]   repeat_ticks_ff;
   logic [STEP_WIDTH-1:0]     temperature_step_ff;
   temp_type                  min_temperature_ff;
   temp_type                  max_temperature_ff;

   // tick state
   button_type                raw_button_ff, raw_button_in;
   logic [DEBOUNCE_WIDTH-1:0] debounce_count_ff, debounce_count_in;
   button_type                qualified_button_ff, qualified_button_in;
   button_type                previous_button_ff, previous_button_in;
   time_type                  last_repeat_time_ff, last_repeat_time_in;
   time_type                  tick_time_ff, tick_time_in;
   temp_type                  target_temperature_ff, target_temperature_in;

   // response buffer
   logic       out_valid_ff, skid_valid_ff;
   result_type out_data_ff, skid_data_ff;
   result_type result;

   logic       req_accept, rsp_taken;
   logic [3:0] levels;
   button_type raw_latched;
   logic       first_press, held_press, act;
   time_type   gap;
   logic [TEMP_WIDTH:0] sum_up;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_taken  = out_valid_ff && !rsp_stall;

   assign rsp_setpoint_value   = out_data_ff.setpoint_value;
   assign rsp_debounced_button = out_data_ff.debounced_button;
   assign rsp_setpoint_changed = out_data_ff.setpoint_changed;

   assign levels = {req_pressed_menu, req_pressed_down, req_pressed_up, req_pressed_enter};

   always_comb begin
      tick_time_in = tick_time_ff + 1'b1;

      // a known edge event overwrites the raw button
      if (req_press_event >= KEY_ENTER && req_press_event <= KEY_MENU) begin
         raw_latched = req_press_event;
      end else begin
         raw_latched = raw_button_ff;
      end

      raw_button_in       = raw_latched;
      debounce_count_in   = debounce_count_ff;
      qualified_button_in = qualified_button_ff;
      if (raw_latched != KEY_NONE) begin
         if (debounce_count_ff != '0) begin
            debounce_count_in = debounce_count_ff - 1'b1;
         end else begin
            if (level_of(raw_latched, levels)) begin
               qualified_button_in = raw_latched;
            end
            debounce_count_in = debounce_ticks_ff;
            raw_button_in     = KEY_NONE;
         end
      end

      // repeat step
      first_press = (qualified_button_in != KEY_NONE) && (last_repeat_time_ff == '0);
      held_press  = (qualified_button_in == previous_button_ff)
                    && level_of(qualified_button_in, levels);
      gap = tick_time_in - last_repeat_time_ff;
      act = 1'b1;
      last_repeat_time_in = last_repeat_time_ff;
      if (first_press || held_press) begin
         if (gap >= time_type'(repeat_ticks_ff)) begin
            last_repeat_time_in = tick_time_in;
         end else begin
            act = 1'b0;
         end
      end else begin
         last_repeat_time_in = '0;
         qualified_button_in = KEY_NONE;
      end

      previous_button_in    = previous_button_ff;
      target_temperature_in = target_temperature_ff;
      sum_up = {1'b0, target_temperature_ff} + (TEMP_WIDTH+1)'(temperature_step_ff);
      if (act) begin
         previous_button_in = qualified_button_in;
         if (qualified_button_in == KEY_UP) begin
            if (target_temperature_ff < max_temperature_ff) begin
               target_temperature_in = sum_up[TEMP_WIDTH] ? SETPOINT_MAX
                                                          : sum_up[TEMP_WIDTH-1:0];
            end
         end else if (qualified_button_in == KEY_DOWN) begin
            if (target_temperature_ff > min_temperature_ff) begin
               if (target_temperature_ff > temp_type'(temperature_step_ff)) begin
                  target_temperature_in = target_temperature_ff
                                          - temp_type'(temperature_step_ff);
               end else begin
                  target_temperature_in = '0;
               end
            end
         end
      end

      result.setpoint_value   = target_temperature_in;
      result.debounced_button = qualified_button_in;
      result.setpoint_changed = target_temperature_in != target_temperature_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff   <= DEBOUNCE_TICKS_RESET;
         repeat_ticks_ff     <= REPEAT_TICKS_RESET;
         temperature_step_ff <= TEMPERATURE_STEP_RESET;
         min_temperature_ff  <= MIN_TEMPERATURE_RESET;
         max_temperature_ff  <= MAX_TEMPERATURE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS:   debounce_ticks_ff   <= csr_write_data[DEBOUNCE_WIDTH-1:0];
            CSR_REPEAT_TICKS:     repeat_ticks_ff     <= csr_write_data[REPEAT_WIDTH-1:0];
            CSR_TEMPERATURE_STEP: temperature_step_ff <= csr_write_data[STEP_WIDTH-1:0];
            CSR_MIN_TEMPERATURE:  min_temperature_ff  <= csr_write_data[TEMP_WIDTH-1:0];
            CSR_MAX_TEMPERATURE:  max_temperature_ff  <= csr_write_data[TEMP_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_button_ff         <= KEY_NONE;
         debounce_count_ff     <= DEBOUNCE_TICKS_RESET;
         qualified_button_ff   <= KEY_NONE;
         previous_button_ff    <= KEY_NONE;
         last_repeat_time_ff   <= '0;
         tick_time_ff          <= '0;
         target_temperature_ff <= SETPOINT_RESET;
      end else if (req_accept) begin
         raw_button_ff         <= raw_button_in;
         debounce_count_ff     <= debounce_count_in;
         qualified_button_ff   <= qualified_button_in;
         previous_button_ff    <= previous_button_in;
         last_repeat_time_ff   <= last_repeat_time_in;
         tick_time_ff          <= tick_time_in;
         target_temperature_ff <= target_temperature_in;
      end
   end

   // two-entry response buffer; the skid entry fills only while the head waits
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (rsp_taken) begin
            out_valid_ff  <= skid_valid_ff || req_accept;
            skid_valid_ff <= 1'b0;
         end else if (req_accept) begin
            if (out_valid_ff) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_taken) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : result;
      end else if (req_accept) begin
         if (out_valid_ff) begin
            skid_data_ff <= result;
         end else begin
            out_data_ff <= result;
         end
      end
   end

endmodule
